/* design/bb3_pkg.sv */
`timescale 1ns / 1ps

package bb3_pkg;

  // One pixel as it sits in the line stores and the window: red, green, blue.
  typedef logic [23:0] pix_t;

  // Input beat.
  typedef struct packed {
    logic       command;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_t;

  // Command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Register widths and reset values.
  localparam int FW_W = 11;
  localparam int FH_W = 12;
  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 12'd480;

  // The row counter runs up to height + 1 while draining.
  localparam int ROW_W = FH_W + 1;

  // Arithmetic widths.
  localparam int CH_W   = 8;
  localparam int NCH    = 3;
  localparam int RSUM_W = 10;  // sum of three channel values
  localparam int SUM_W  = 12;  // sum of nine channel values
  localparam int NUM_W  = 13;  // 2 * sum + count
  localparam int RCP_W  = 14;
  localparam int PROD_W = NUM_W + RCP_W;

  // Window pixel counts: corner, border, inner.
  localparam logic [NUM_W-1:0] N_CORNER = 13'd4;
  localparam logic [NUM_W-1:0] N_BORDER = 13'd6;
  localparam logic [NUM_W-1:0] N_INNER  = 13'd9;

  // Reciprocals of 2 * count, scaled by 2**RCP_SHIFT. They give exact floors
  // for every numerator below 2**NUM_W.
  localparam int RCP_SHIFT = 16;
  localparam logic [RCP_W-1:0] RCP_CORNER = 14'd8192;
  localparam logic [RCP_W-1:0] RCP_BORDER = 14'd5462;
  localparam logic [RCP_W-1:0] RCP_INNER  = 14'd3641;

endpackage

/* design/box_blur_3x3_edge_clipped_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in_       input      in_valid / in_stall      in_data (command, RGB pixel)
// out_      output     out_valid / out_stall    out_data (blurred RGB, frame_end)
// config    APB write  psel, penable, pwrite    paddr, pwdata, prdata (pready tied)
//
// One beat per clock while in_stall is low: the line stores are read ahead at the
// next column, so each beat does its read-modify-write in the cycle it is taken.
// A result passes the averaging pipeline of snapshot, sum rows, sum window,
// reciprocal multiply and output registers before it leaves.
// Reset clears the counters, the pipeline valids and the registers to
// 640 x 480; line stores and window are not cleared.
// A stalled output holds its beat; bubbles in the pipeline still close up, and
// the input stalls only when every stage is full.

module box_blur_3x3_edge_clipped_unit
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int EW_W  = (WID_W > FW_W) ? WID_W : FW_W;

  // Configuration registers.
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic            cfg_wr;
  logic            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  fw_r <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: prdata = 32'(fh_r);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size after clamping.
  logic [EW_W-1:0]  fw_ext;
  logic [EW_W-1:0]  eff_w;
  logic [FH_W-1:0]  eff_h;
  logic [ROW_W-1:0] h_ext;

  assign fw_ext = EW_W'(fw_r);

  always_comb begin
    if (fw_ext < EW_W'(2)) begin
      eff_w = EW_W'(2);
    end else if (fw_ext > EW_W'(MAX_WIDTH)) begin
      eff_w = EW_W'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
  end

  assign eff_h = (fh_r < FH_W'(2)) ? FH_W'(2) : fh_r;
  assign h_ext = ROW_W'(eff_h);

  // Pipeline handshake: each stage takes a new beat when it is empty or moves on.
  logic va_r, vb_r, vc_r, vd_r, out_valid_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  assign rdy_o    = !out_valid_r || !out_stall;
  assign rdy_d    = !vd_r || rdy_o;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_stall = !rdy_a;

  // Position of the next beat and what it does.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_accept;
  logic             is_drain;
  logic             step_ok;
  logic             j0;
  logic             has_out;
  logic             is_last;
  logic [ROW_W-1:0] crow;
  logic [EW_W-1:0]  col_inc;
  pix_t             pix;

  assign in_accept = in_valid && !in_stall;
  assign is_drain  = (in_data.command == CMD_DRAIN);
  // A drain before the last pixel, or a pixel after it, changes nothing.
  assign step_ok   = in_accept && (is_drain == (row_r >= h_ext));
  assign j0        = (col_r == '0);
  assign pix       = is_drain ? '0 : {in_data.in_red, in_data.in_green, in_data.in_blue};
  // At column zero the finished center is the last column two rows back.
  assign crow      = j0 ? (row_r - ROW_W'(2)) : (row_r - ROW_W'(1));
  assign has_out   = j0 ? (row_r >= ROW_W'(2)) : (row_r >= ROW_W'(1));
  assign is_last   = j0 && (row_r == h_ext + ROW_W'(1));
  assign col_inc   = EW_W'(col_r) + EW_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (!rst_n || cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (step_ok) begin
      if (has_out && is_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= eff_w) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores: read ahead at the next column, rotate on write. A read of the
  // column being written takes the write data.
  pix_t upper_mem [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t upper_q_r;
  pix_t mid_q_r;
  logic fwd;

  assign fwd = step_ok && (col_r == col_nxt);

  always_ff @(posedge clk) begin
    if (step_ok) begin
      upper_mem[col_r] <= mid_q_r;
    end
    upper_q_r <= fwd ? mid_q_r : upper_mem[col_nxt];
  end

  always_ff @(posedge clk) begin
    if (step_ok) begin
      middle_mem[col_r] <= pix;
    end
    mid_q_r <= fwd ? pix : middle_mem[col_nxt];
  end

  // Window shifts left by one column on every beat that takes effect.
  pix_t win_r   [3][3];
  pix_t win_nxt [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = upper_q_r;
    win_nxt[1][2] = mid_q_r;
    win_nxt[2][2] = pix;
  end

  always_ff @(posedge clk) begin
    if (step_ok) begin
      win_r <= win_nxt;
    end
  end

  // Stage A: snapshot of the window with its clipping flags.
  pix_t win_a_r [3][3];
  logic top_a_r, bot_a_r, left_a_r, right_a_r, last_a_r;

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      win_a_r   <= win_nxt;
      top_a_r   <= (crow != '0);
      bot_a_r   <= (crow != h_ext - ROW_W'(1));
      // At column zero the window's last column is already the next row.
      left_a_r  <= (col_r != COL_W'(1));
      right_a_r <= !j0;
      last_a_r  <= is_last;
    end
  end

  // Stage B: per row sums over the kept columns.
  logic [RSUM_W-1:0] rsum_b_r [NCH][3];
  logic [RSUM_W-1:0] rsum_nxt [NCH][3];
  logic              top_b_r, bot_b_r, row3_b_r, col3_b_r, last_b_r;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      for (int r = 0; r < 3; r++) begin
        rsum_nxt[k][r] = (left_a_r ? RSUM_W'(win_a_r[r][0][CH_W*k +: CH_W]) : '0)
                       + RSUM_W'(win_a_r[r][1][CH_W*k +: CH_W])
                       + (right_a_r ? RSUM_W'(win_a_r[r][2][CH_W*k +: CH_W]) : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      rsum_b_r <= rsum_nxt;
      top_b_r  <= top_a_r;
      bot_b_r  <= bot_a_r;
      row3_b_r <= top_a_r && bot_a_r;
      col3_b_r <= left_a_r && right_a_r;
      last_b_r <= last_a_r;
    end
  end

  // Stage C: window sum and rounding numerator 2 * sum + count.
  logic [NUM_W-1:0] num_c_r [NCH];
  logic [NUM_W-1:0] num_nxt [NCH];
  logic [SUM_W-1:0] sum_nxt [NCH];
  logic [NUM_W-1:0] cnt_b;
  logic             inner_c_r, corner_c_r, last_c_r;

  assign cnt_b = (row3_b_r && col3_b_r) ? N_INNER :
                 (!row3_b_r && !col3_b_r) ? N_CORNER : N_BORDER;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      sum_nxt[k] = (top_b_r ? SUM_W'(rsum_b_r[k][0]) : '0)
                 + SUM_W'(rsum_b_r[k][1])
                 + (bot_b_r ? SUM_W'(rsum_b_r[k][2]) : '0);
      num_nxt[k] = {sum_nxt[k], 1'b0} + cnt_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      num_c_r    <= num_nxt;
      inner_c_r  <= row3_b_r && col3_b_r;
      corner_c_r <= !row3_b_r && !col3_b_r;
      last_c_r   <= last_b_r;
    end
  end

  // Stage D: divide by 2 * count as a multiply by its scaled reciprocal.
  logic [PROD_W-1:0] prod_d_r [NCH];
  logic [RCP_W-1:0]  rcp_c;
  logic              last_d_r;

  assign rcp_c = inner_c_r ? RCP_INNER : (corner_c_r ? RCP_CORNER : RCP_BORDER);

  always_ff @(posedge clk) begin
    if (rdy_d) begin
      for (int k = 0; k < NCH; k++) begin
        prod_d_r[k] <= PROD_W'(num_c_r[k]) * PROD_W'(rcp_c);
      end
      last_d_r <= last_c_r;
    end
  end

  // Output register.
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_data_r.out_red   <= prod_d_r[2][RCP_SHIFT +: CH_W];
      out_data_r.out_green <= prod_d_r[1][RCP_SHIFT +: CH_W];
      out_data_r.out_blue  <= prod_d_r[0][RCP_SHIFT +: CH_W];
      out_data_r.frame_end <= last_d_r;
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= step_ok && has_out;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_o) out_valid_r <= vd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the position counters.
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    EW_W'(col_r) < eff_w)
    else $error("column counter beyond frame width");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= h_ext + ROW_W'(1))
    else $error("row counter beyond drain range");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step_ok && has_out && is_last) |=> (row_r == '0 && col_r == '0))
    else $error("frame end did not restart the position counters");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (va_r && vb_r && vc_r && vd_r && out_valid_r))
    else $error("input stalled while the pipeline has room");

endmodule
